// File: rtl/core/fixed_point_alu_q24_8_unit_defines.svh
// ----------------------------------------------------------------------------
// fixed point alu assertion macros
// shared property forms for the q24.8 alu checks
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// types and constants shared by the q24.8 fixed point alu
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 8;
  localparam int QuoBits   = DataWidth + FracBits;
  // front, one stage per quotient bit, round, pack
  localparam int Latency   = QuoBits + 3;
  localparam int MulMerge  = 3;

  typedef enum logic [3:0] {
    KIND_ADD     = 4'd0,
    KIND_SUB     = 4'd1,
    KIND_MUL     = 4'd2,
    KIND_DIV     = 4'd3,
    KIND_GT      = 4'd4,
    KIND_LT      = 4'd5,
    KIND_GE      = 4'd6,
    KIND_LE      = 4'd7,
    KIND_EQ      = 4'd8,
    KIND_NE      = 4'd9,
    KIND_MIN     = 4'd10,
    KIND_MAX     = 4'd11,
    KIND_INC     = 4'd12,
    KIND_DEC     = 4'd13,
    KIND_TOINT   = 4'd14,
    KIND_FROMINT = 4'd15
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  localparam logic signed [DataWidth-1:0] SatMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] SatMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef struct packed {
    kind_t                       kind;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_raw;
    logic                        compare_flag;
    status_t                     status;
  } rsp_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [DataWidth-1:0] res;
    logic                        flag;
    status_t                     st;
  } line_t;

  typedef struct packed {
    line_t                base;
    logic                 neg_a;
    logic                 neg_b;
    logic [DataWidth-1:0] mag_a;
    logic [DataWidth-1:0] mag_b;
    logic                 b_zero;
  } front_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res;
    status_t                     st;
  } arith_t;

endpackage

`default_nettype wire

// File: rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// first stage: operations finished in this stage, and operand magnitudes
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire fpa_pkg::req_t req,
  output fpa_pkg::front_t    front
);
  import fpa_pkg::*;

  logic signed [DataWidth:0]   ext_a;
  logic signed [DataWidth:0]   addend;
  logic signed [DataWidth:0]   sum;
  logic signed [DataWidth-1:0] sum_sat;
  logic                        sum_ovf;
  logic                        na, nb;
  logic                        from_ovf;
  line_t                       base_next;

  assign na      = req.operand_a[DataWidth-1];
  assign nb      = req.operand_b[DataWidth-1];
  assign ext_a   = {na, req.operand_a};
  assign sum     = ext_a + addend;
  assign sum_ovf = sum[DataWidth] != sum[DataWidth-1];
  assign sum_sat = sum_ovf ? (sum[DataWidth] ? SatMin : SatMax) : sum[DataWidth-1:0];
  // a << frac fits when the top frac+1 bits all match the sign
  assign from_ovf = (req.operand_a[DataWidth-1:DataWidth-1-FracBits] != '0) &&
                    (req.operand_a[DataWidth-1:DataWidth-1-FracBits] != '1);

  always_comb begin
    addend = '0;
    unique case (req.kind)
      KIND_ADD: addend = {nb, req.operand_b};
      KIND_SUB: addend = -$signed({nb, req.operand_b});
      KIND_INC: addend = (DataWidth+1)'(1);
      KIND_DEC: addend = '1;
      default:  addend = '0;
    endcase
  end

  always_comb begin
    base_next      = '0;
    base_next.kind = req.kind;
    unique case (req.kind)
      KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
        base_next.res = sum_sat;
        base_next.st  = sum_ovf ? ST_OVF : ST_OK;
      end
      KIND_MUL, KIND_DIV: base_next.res = '0;
      KIND_GT: base_next.flag = req.operand_a >  req.operand_b;
      KIND_LT: base_next.flag = req.operand_a <  req.operand_b;
      KIND_GE: base_next.flag = req.operand_a >= req.operand_b;
      KIND_LE: base_next.flag = req.operand_a <= req.operand_b;
      KIND_EQ: base_next.flag = req.operand_a == req.operand_b;
      KIND_NE: base_next.flag = req.operand_a != req.operand_b;
      KIND_MIN: base_next.res = (req.operand_a < req.operand_b) ? req.operand_a : req.operand_b;
      KIND_MAX: base_next.res = (req.operand_a > req.operand_b) ? req.operand_a : req.operand_b;
      KIND_TOINT: base_next.res = req.operand_a >>> FracBits;
      KIND_FROMINT: begin
        base_next.res = from_ovf ? (na ? SatMin : SatMax) : (req.operand_a <<< FracBits);
        base_next.st  = from_ovf ? ST_OVF : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front.base   <= base_next;
      front.neg_a  <= na;
      front.neg_b  <= nb;
      front.mag_a  <= na ? DataWidth'(-req.operand_a) : DataWidth'(req.operand_a);
      front.mag_b  <= nb ? DataWidth'(-req.operand_b) : DataWidth'(req.operand_b);
      front.b_zero <= req.operand_b == '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// two-stage magnitude multiply with rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_mul (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire fpa_pkg::front_t front,
  output fpa_pkg::arith_t      mul
);
  import fpa_pkg::*;

  localparam int ProdBits = 2 * DataWidth;

  logic [ProdBits-1:0] prod;
  logic                neg;
  logic [ProdBits:0]   rounded;
  logic [ProdBits:0]   shifted;
  logic [ProdBits:0]   limit;
  logic                ovf;
  logic [DataWidth-1:0] mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= ProdBits'(front.mag_a) * ProdBits'(front.mag_b);
      neg  <= front.neg_a ^ front.neg_b;
    end
  end

  assign rounded = {1'b0, prod} + ((ProdBits+1)'(1) << (FracBits-1));
  assign shifted = rounded >> FracBits;
  assign limit   = (ProdBits+1)'({1'b0, {(DataWidth-1){1'b1}}}) + (ProdBits+1)'(neg);
  assign ovf     = shifted > limit;
  assign mag     = shifted[DataWidth-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      mul.res <= ovf ? (neg ? SatMin : SatMax) : (neg ? -mag : mag);
      mul.st  <= ovf ? ST_OVF : ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// restoring divider, one quotient bit per stage, then round and pack
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire fpa_pkg::front_t front,
  output fpa_pkg::arith_t      div
);
  import fpa_pkg::*;

  logic [DataWidth-1:0] rem_s  [1:QuoBits];
  logic [QuoBits-1:0]   quo_s  [1:QuoBits];
  logic [DataWidth-1:0] den_s  [1:QuoBits];
  logic [DataWidth-1:0] mag_s  [1:QuoBits];
  logic                 neg_s  [1:QuoBits];
  logic                 zero_s [1:QuoBits];

  for (genvar k = 1; k <= QuoBits; k++) begin : g_bit
    localparam int BitPos = QuoBits - k;
    logic [DataWidth-1:0] rem_in, den_in, mag_in, rem_sh;
    logic [QuoBits-1:0]   quo_in;
    logic                 neg_in, zero_in, din, take;

    if (k == 1) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign den_in  = front.mag_b;
      assign mag_in  = front.mag_a;
      assign neg_in  = front.neg_a ^ front.neg_b;
      assign zero_in = front.b_zero;
    end else begin : g_rest
      assign rem_in  = rem_s[k-1];
      assign quo_in  = quo_s[k-1];
      assign den_in  = den_s[k-1];
      assign mag_in  = mag_s[k-1];
      assign neg_in  = neg_s[k-1];
      assign zero_in = zero_s[k-1];
    end

    // dividend is magnitude of a followed by frac zero bits
    if (BitPos >= FracBits) begin : g_abit
      assign din = mag_in[BitPos-FracBits];
    end else begin : g_zbit
      assign din = 1'b0;
    end

    assign rem_sh = {rem_in[DataWidth-2:0], din};
    assign take   = rem_sh >= den_in;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k]  <= take ? rem_sh - den_in : rem_sh;
        quo_s[k]  <= {quo_in[QuoBits-2:0], take};
        den_s[k]  <= den_in;
        mag_s[k]  <= mag_in;
        neg_s[k]  <= neg_in;
        zero_s[k] <= zero_in;
      end
    end
  end

  // round to nearest, ties away: bump when twice the remainder reaches the divisor
  logic                 rnd;
  logic [QuoBits:0]     quo_r;
  logic                 neg_r, zero_r;
  logic [QuoBits:0]     limit;
  logic                 ovf;
  logic [DataWidth-1:0] mag;

  assign rnd = {rem_s[QuoBits], 1'b0} >= {1'b0, den_s[QuoBits]};

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r  <= {1'b0, quo_s[QuoBits]} + (QuoBits+1)'(rnd);
      neg_r  <= neg_s[QuoBits];
      zero_r <= zero_s[QuoBits];
    end
  end

  assign limit = (QuoBits+1)'({1'b0, {(DataWidth-1){1'b1}}}) + (QuoBits+1)'(neg_r);
  assign ovf   = quo_r > limit;
  assign mag   = quo_r[DataWidth-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (zero_r) begin
        div.res <= '0;
        div.st  <= ST_DIV0;
      end else if (ovf) begin
        div.res <= neg_r ? SatMin : SatMax;
        div.st  <= ST_OVF;
      end else begin
        div.res <= neg_r ? -mag : mag;
        div.st  <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fixed_point_alu_q24_8_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_unit
// pipelined signed q24.8 alu: add, sub, inc, dec, mul, div, compares, min/max, conversions
// ----------------------------------------------------------------------------
// usage
//   request channel: req carries kind and two raw operands; it is taken on a
//   rising edge with req_valid high and req_stall low
//   response channel: rsp carries result_raw, compare_flag and status; it is
//   taken on a rising edge with rsp_valid high and rsp_stall low
//   ordering: every request gives one response, whatever its kind; responses
//   leave in request order
//   throughput: one request per cycle while req_stall is low; the depth is set by
//   the divider, which resolves one quotient bit per stage over 40 stages, plus a
//   front stage, a rounding stage and a packing stage
//   stall: when the last stage holds a response and rsp_stall is high the
//   whole pipeline freezes and req_stall rises; the response holds steady
//   reset: rst clears every stage valid bit; data registers keep their
//   contents, which nothing looks at until a valid bit sets again
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire fpa_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output fpa_pkg::rsp_t      rsp
);
  import fpa_pkg::*;

  // global advance: the pipe moves unless a held response is stalled
  logic   adv;
  logic   valid [0:Latency-1];
  line_t  line  [1:Latency-1];
  front_t front;
  arith_t mul;
  arith_t div;
  line_t  merged;
  line_t  last;

  assign adv       = !(valid[Latency-1] && rsp_stall);
  assign req_stall = !adv;
  assign rsp_valid = valid[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Latency; k++) begin
        valid[k] <= 1'b0;
      end
    end else if (adv) begin
      valid[0] <= req_valid;
      for (int k = 1; k < Latency; k++) begin
        valid[k] <= valid[k-1];
      end
    end
  end

  // front stage: ops finished in this stage, and magnitudes for the long units
  fpa_front u_front (
    .clk   (clk),
    .adv   (adv),
    .req   (req),
    .front (front)
  );

  // multiplier result lines up with line entry two
  fpa_mul u_mul (
    .clk   (clk),
    .adv   (adv),
    .front (front),
    .mul   (mul)
  );

  // divider result lines up with the last line entry
  fpa_div u_div (
    .clk   (clk),
    .adv   (adv),
    .front (front),
    .div   (div)
  );

  // fold the multiply result in as the line passes it
  always_comb begin
    merged = line[MulMerge-1];
    if (line[MulMerge-1].kind == KIND_MUL) begin
      merged.res = mul.res;
      merged.st  = mul.st;
    end
  end

  // side line carrying kind and early results alongside the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      line[1] <= front.base;
      for (int k = 2; k < Latency; k++) begin
        line[k] <= (k == MulMerge) ? merged : line[k-1];
      end
    end
  end

  // output selection from registered values; frozen while stalled
  always_comb begin
    last = line[Latency-1];
    if (last.kind == KIND_DIV) begin
      last.res = div.res;
      last.st  = div.st;
    end
    rsp.result_raw   = last.res;
    rsp.compare_flag = last.flag;
    rsp.status       = last.st;
  end

`include "fixed_point_alu_q24_8_unit_defines.svh"

  // a divide by zero always reports a zero result
  `FPA_ASSERT_NOW(a_div0_zero, rsp_valid && rsp.status == ST_DIV0, rsp.result_raw == '0 && !rsp.compare_flag, "divide by zero with nonzero result")
  // a raised compare flag comes with a clean zero result
  `FPA_ASSERT_NOW(a_flag_clean, rsp_valid && rsp.compare_flag, rsp.result_raw == '0 && rsp.status == ST_OK, "compare flag with result or status")
  // a taken request enters the front stage
  `FPA_ASSERT_NEXT(a_enter, req_valid && !req_stall, valid[0], "taken request lost at the front")

endmodule

`default_nettype wire
